### rtl/cll_pkg.sv
// shared types, codes and defaults for the cursor linked list engine
`timescale 1ns / 1ps
package cll_pkg;

   localparam int SPACE_SIZE_DEF    = 256;
   localparam int ELEMENT_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      CMD_INIT        = 3'd0,
      CMD_MAKE_EMPTY  = 3'd1,
      CMD_INSERT      = 3'd2,
      CMD_DELETE      = 3'd3,
      CMD_FIND        = 3'd4,
      CMD_DELETE_LIST = 3'd5,
      CMD_READ_NODE   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_SPACE  = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [7:0]         list_head;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0]         result_position;
      logic signed [31:0] element_out;
      logic [7:0]         next_out;
      logic [1:0]         status;
   } rsp_type;

endpackage

### rtl/cll_chan_if.sv
// valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps
interface cll_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/cll_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module cll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/cursor_linked_list_engine_top.sv
// cursor linked list engine: node store, free chain and command sequencer
//
// Usage: one command per req transfer (cmd, list_head, position, value),
// one rsp transfer per command (result_position, element_out, next_out,
// status). Commands run one at a time; req.ready is high only while the
// sequencer is idle. A finished result sits in the rsp register, and the
// next command may be taken while it waits; a second result waits in the
// sequencer until the rsp register frees up, so a stalled receiver stops
// the block only after one more command.
// The walks are bounded to S = SPACE_SIZE steps; head and position above
// S - 1 are brought into range by repeated subtraction of S.
// Reset starts a sweep over all S nodes that builds the free chain
// i -> i + 1, with the last node linking to 0; req.ready stays low until
// it ends. Element contents are not cleared.
`timescale 1ns / 1ps
module cursor_linked_list_engine_top #(
   parameter int SPACE_SIZE    = cll_pkg::SPACE_SIZE_DEF,
   parameter int ELEMENT_WIDTH = cll_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cll_chan_if.sink    req,
   cll_chan_if.source  rsp
);
   localparam int IW  = $clog2(SPACE_SIZE);
   localparam int SW  = $clog2(SPACE_SIZE + 1);
   localparam int WRW = (IW > 8) ? IW : 8;
   localparam int EW  = ELEMENT_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRAP, ST_SWEEP,
      ST_FA_HEAD, ST_FA_CLR, ST_FL_CHECK, ST_FL_RD_NXT, ST_FL_GET_NXT,
      ST_FL_GET_F, ST_FL_LINK,
      ST_AL_RD0, ST_AL_T, ST_AL_N, ST_ME_SET, ST_IN_RDPOS, ST_IN_M, ST_IN_LINK,
      ST_DL_RD, ST_DL_N, ST_DL_E, ST_DL_VN, ST_GV_RD0, ST_GV_F, ST_GV_LINK,
      ST_FD_HEAD, ST_FD_P, ST_FD_CHK, ST_FD_CMP,
      ST_RN_RD, ST_RN_DATA, ST_FINISH
   } state_type;

   state_type       state_ff;
   logic            booting_ff;
   logic [IW-1:0]   sweep_ff;
   logic [2:0]      cmd_ff;
   logic [WRW-1:0]  head_w_ff;
   logic [WRW-1:0]  pos_w_ff;
   logic [EW-1:0]   val_ff;
   logic [IW-1:0]   cur_ff;
   logic [IW-1:0]   tmp_ff;
   logic [SW-1:0]   steps_ff;
   logic [IW-1:0]   res_pos_ff;
   logic [31:0]     res_elem_ff;
   logic [IW-1:0]   res_next_ff;
   logic [1:0]      res_status_ff;
   logic            rsp_valid_ff;
   cll_pkg::rsp_type rsp_ff;

   logic            nx_we;
   logic [IW-1:0]   nx_waddr;
   logic [IW-1:0]   nx_wdata;
   logic [IW-1:0]   nx_raddr;
   logic [IW-1:0]   nx_rdata;
   logic            el_we;
   logic [IW-1:0]   el_waddr;
   logic [IW-1:0]   el_raddr;
   logic [EW-1:0]   el_rdata;

   logic [63:0]     val_sx;
   logic [EW-1:0]   val_conv;
   logic [63:0]     elem_zx;
   logic            head_big;
   logic            pos_big;
   logic [IW-1:0]   head_idx;
   logic [IW-1:0]   pos_idx;
   logic            elem_hit;
   logic [SW-1:0]   steps_inc;
   logic [31:0]     res_pos_zx;
   logic [31:0]     res_next_zx;

   cll_ram #(.WIDTH(IW), .DEPTH(SPACE_SIZE)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   cll_ram #(.WIDTH(EW), .DEPTH(SPACE_SIZE)) u_elem_ram (
      .clock   (clock),
      .wr_en   (el_we),
      .wr_addr (el_waddr),
      .wr_data (val_ff),
      .rd_addr (el_raddr),
      .rd_data (el_rdata)
   );

   // value is sign-extended from 32 bits, then cut to the element width
   assign val_sx   = 64'(signed'(req.payload.value));
   assign val_conv = val_sx[EW-1:0];
   assign elem_zx  = 64'(el_rdata);

   // index wrap by repeated subtraction, one step per cycle
   assign head_big  = {1'b0, head_w_ff} >= (WRW + 1)'(SPACE_SIZE);
   assign pos_big   = {1'b0, pos_w_ff} >= (WRW + 1)'(SPACE_SIZE);
   assign head_idx  = head_w_ff[IW-1:0];
   assign pos_idx   = pos_w_ff[IW-1:0];
   assign elem_hit  = (el_rdata == val_ff);
   assign steps_inc = steps_ff + SW'(1);

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = '0;
      nx_wdata = '0;
      nx_raddr = '0;
      el_we    = 1'b0;
      el_waddr = tmp_ff;
      el_raddr = cur_ff;
      case (state_ff)
         ST_SWEEP: begin
            nx_we    = 1'b1;
            nx_waddr = sweep_ff;
            nx_wdata = (sweep_ff == IW'(SPACE_SIZE - 1)) ? '0 : IW'(sweep_ff + IW'(1));
         end
         ST_FA_HEAD: nx_raddr = head_idx;
         ST_FA_CLR: begin
            nx_we    = 1'b1;
            nx_waddr = head_idx;
         end
         ST_FL_RD_NXT: nx_raddr = cur_ff;
         ST_FL_GET_F: begin
            nx_we    = 1'b1;
            nx_waddr = cur_ff;
            nx_wdata = nx_rdata;
         end
         ST_FL_LINK: begin
            nx_we    = 1'b1;
            nx_wdata = cur_ff;
         end
         ST_AL_T: nx_raddr = nx_rdata;
         ST_AL_N: begin
            nx_we    = 1'b1;
            nx_wdata = nx_rdata;
            el_we    = (cmd_ff == cll_pkg::CMD_INSERT);
         end
         ST_ME_SET: begin
            nx_we    = 1'b1;
            nx_waddr = tmp_ff;
         end
         ST_IN_RDPOS: nx_raddr = pos_idx;
         ST_IN_M: begin
            nx_we    = 1'b1;
            nx_waddr = tmp_ff;
            nx_wdata = nx_rdata;
         end
         ST_IN_LINK: begin
            nx_we    = 1'b1;
            nx_waddr = pos_idx;
            nx_wdata = tmp_ff;
         end
         ST_DL_RD: nx_raddr = cur_ff;
         ST_DL_N: el_raddr = nx_rdata;
         ST_DL_E: nx_raddr = tmp_ff;
         ST_DL_VN: begin
            nx_we    = 1'b1;
            nx_waddr = cur_ff;
            nx_wdata = nx_rdata;
         end
         ST_GV_F: begin
            nx_we    = 1'b1;
            nx_waddr = tmp_ff;
            nx_wdata = nx_rdata;
         end
         ST_GV_LINK: begin
            nx_we    = 1'b1;
            nx_wdata = tmp_ff;
         end
         ST_FD_HEAD: nx_raddr = head_idx;
         ST_FD_CHK: nx_raddr = cur_ff;
         ST_RN_RD: begin
            nx_raddr = pos_idx;
            el_raddr = pos_idx;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         booting_ff   <= 1'b1;
         sweep_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  cmd_ff    <= req.payload.cmd;
                  head_w_ff <= WRW'(req.payload.list_head);
                  pos_w_ff  <= WRW'(req.payload.position);
                  val_ff    <= val_conv;
                  state_ff  <= ST_WRAP;
               end
            end
            ST_WRAP: begin
               if (head_big) begin
                  head_w_ff <= head_w_ff - WRW'(SPACE_SIZE);
               end
               if (pos_big) begin
                  pos_w_ff <= pos_w_ff - WRW'(SPACE_SIZE);
               end
               if (!head_big && !pos_big) begin
                  res_pos_ff    <= '0;
                  res_elem_ff   <= '0;
                  res_next_ff   <= '0;
                  res_status_ff <= cll_pkg::STAT_OK;
                  steps_ff      <= '0;
                  cur_ff        <= head_idx;
                  case (cmd_ff)
                     cll_pkg::CMD_INIT: begin
                        sweep_ff <= '0;
                        state_ff <= ST_SWEEP;
                     end
                     cll_pkg::CMD_MAKE_EMPTY:
                        state_ff <= (head_idx != '0) ? ST_FA_HEAD : ST_AL_RD0;
                     cll_pkg::CMD_INSERT:      state_ff <= ST_AL_RD0;
                     cll_pkg::CMD_DELETE:      state_ff <= ST_DL_RD;
                     cll_pkg::CMD_FIND:        state_ff <= ST_FD_HEAD;
                     cll_pkg::CMD_DELETE_LIST: state_ff <= ST_FA_HEAD;
                     cll_pkg::CMD_READ_NODE:   state_ff <= ST_RN_RD;
                     default:                  state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + IW'(1);
               if (sweep_ff == IW'(SPACE_SIZE - 1)) begin
                  booting_ff <= 1'b0;
                  state_ff   <= booting_ff ? ST_IDLE : ST_FINISH;
               end
            end
            // free every node after the head
            ST_FA_HEAD: state_ff <= ST_FA_CLR;
            ST_FA_CLR: begin
               cur_ff   <= nx_rdata;
               state_ff <= ST_FL_CHECK;
            end
            ST_FL_CHECK: begin
               if (cur_ff != '0 && steps_ff != SW'(SPACE_SIZE)) begin
                  state_ff <= ST_FL_RD_NXT;
               end else if (cmd_ff == cll_pkg::CMD_MAKE_EMPTY) begin
                  state_ff <= ST_AL_RD0;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FL_RD_NXT:  state_ff <= ST_FL_GET_NXT;
            ST_FL_GET_NXT: begin
               tmp_ff   <= nx_rdata;
               state_ff <= ST_FL_GET_F;
            end
            ST_FL_GET_F:   state_ff <= ST_FL_LINK;
            ST_FL_LINK: begin
               cur_ff   <= tmp_ff;
               steps_ff <= steps_inc;
               state_ff <= ST_FL_CHECK;
            end
            // allocation from the free chain
            ST_AL_RD0: state_ff <= ST_AL_T;
            ST_AL_T: begin
               tmp_ff <= nx_rdata;
               if (nx_rdata == '0) begin
                  res_status_ff <= cll_pkg::STAT_NO_SPACE;
                  state_ff      <= ST_FINISH;
               end else begin
                  state_ff <= ST_AL_N;
               end
            end
            ST_AL_N:
               state_ff <= (cmd_ff == cll_pkg::CMD_MAKE_EMPTY) ? ST_ME_SET : ST_IN_RDPOS;
            ST_ME_SET: begin
               res_pos_ff <= tmp_ff;
               state_ff   <= ST_FINISH;
            end
            ST_IN_RDPOS: state_ff <= ST_IN_M;
            ST_IN_M:     state_ff <= ST_IN_LINK;
            ST_IN_LINK: begin
               res_pos_ff <= tmp_ff;
               state_ff   <= ST_FINISH;
            end
            // delete walk: cur is the predecessor, tmp the candidate
            ST_DL_RD: state_ff <= ST_DL_N;
            ST_DL_N: begin
               tmp_ff <= nx_rdata;
               if (nx_rdata == '0) begin
                  res_status_ff <= cll_pkg::STAT_NOT_FOUND;
                  state_ff      <= ST_FINISH;
               end else begin
                  state_ff <= ST_DL_E;
               end
            end
            ST_DL_E: begin
               if (elem_hit) begin
                  state_ff <= ST_DL_VN;
               end else begin
                  cur_ff   <= tmp_ff;
                  steps_ff <= steps_inc;
                  if (steps_inc == SW'(SPACE_SIZE)) begin
                     res_status_ff <= cll_pkg::STAT_NOT_FOUND;
                     state_ff      <= ST_FINISH;
                  end else begin
                     state_ff <= ST_DL_RD;
                  end
               end
            end
            ST_DL_VN:  state_ff <= ST_GV_RD0;
            ST_GV_RD0: state_ff <= ST_GV_F;
            ST_GV_F:   state_ff <= ST_GV_LINK;
            ST_GV_LINK: begin
               res_pos_ff <= tmp_ff;
               state_ff   <= ST_FINISH;
            end
            // find walk
            ST_FD_HEAD: state_ff <= ST_FD_P;
            ST_FD_P: begin
               cur_ff   <= nx_rdata;
               state_ff <= ST_FD_CHK;
            end
            ST_FD_CHK: begin
               if (cur_ff == '0) begin
                  res_status_ff <= cll_pkg::STAT_NOT_FOUND;
                  state_ff      <= ST_FINISH;
               end else begin
                  state_ff <= ST_FD_CMP;
               end
            end
            ST_FD_CMP: begin
               if (elem_hit) begin
                  res_pos_ff <= cur_ff;
                  state_ff   <= ST_FINISH;
               end else if (steps_ff == SW'(SPACE_SIZE)) begin
                  res_status_ff <= cll_pkg::STAT_NOT_FOUND;
                  state_ff      <= ST_FINISH;
               end else begin
                  cur_ff   <= nx_rdata;
                  steps_ff <= steps_inc;
                  state_ff <= ST_FD_CHK;
               end
            end
            ST_RN_RD: state_ff <= ST_RN_DATA;
            ST_RN_DATA: begin
               res_elem_ff <= elem_zx[31:0];
               res_next_ff <= nx_rdata;
               state_ff    <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.result_position <= res_pos_zx[7:0];
                  rsp_ff.element_out     <= res_elem_ff;
                  rsp_ff.next_out        <= res_next_zx[7:0];
                  rsp_ff.status          <= res_status_ff;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end else if (rsp_valid_ff && rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign res_pos_zx  = 32'(res_pos_ff);
   assign res_next_zx = 32'(res_next_ff);

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_accept_starts_wrap: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == ST_WRAP)
      else $error("accepted command did not start");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!rsp_valid_ff || rsp.ready) |=> rsp_valid_ff)
      else $error("finished result not loaded into rsp register");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_ff != ST_WRAP |-> steps_ff <= SW'(SPACE_SIZE))
      else $error("walk ran past the store size");

   a_index_wrapped: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_ff != ST_WRAP && !booting_ff |-> !head_big && !pos_big)
      else $error("index used before wrap completed");
endmodule

### bench/cursor_linked_list_engine_top_tb.sv
// self-checking bench for the cursor linked list engine with a node store predictor
`timescale 1ns / 1ps
module cursor_linked_list_engine_top_tb;

   localparam int NODES = 256;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cll_chan_if #(.payload_type(cll_pkg::req_type)) req_ch ();
   cll_chan_if #(.payload_type(cll_pkg::rsp_type)) rsp_ch ();

   cursor_linked_list_engine_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predictor copy of the node store
   logic [7:0]  model_next [NODES];
   logic [31:0] model_elem [NODES];
   bit          elem_written [NODES];

   cll_pkg::req_type pending_cmds [$];
   cll_pkg::rsp_type expected_rsps [$];
   int      error_count = 0;
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;
   int      idle_cycles = 0;

   function automatic void rebuild_free_chain();
      for (int i = 0; i < NODES; i++) model_next[i] = 8'((i + 1) % NODES);
   endfunction

   function automatic logic [7:0] take_node();
      logic [7:0] p;
      p = model_next[0];
      if (p != 0) model_next[0] = model_next[p];
      return p;
   endfunction

   function automatic void give_node(logic [7:0] p);
      model_next[p] = model_next[0];
      model_next[0] = p;
   endfunction

   function automatic void free_after(logic [7:0] hd);
      logic [7:0] p, nx;
      int steps;
      p = model_next[hd];
      steps = 0;
      model_next[hd] = 0;
      while (p != 0 && steps < NODES) begin
         nx = model_next[p];
         give_node(p);
         p = nx;
         steps++;
      end
   endfunction

   // apply one command to the predictor and return its response
   function automatic cll_pkg::rsp_type apply_command(cll_pkg::req_type c);
      cll_pkg::rsp_type r;
      logic [7:0] t, p, n, victim;
      int steps;
      bit hit;
      r = '0;
      case (c.cmd)
         cll_pkg::CMD_INIT: rebuild_free_chain();
         cll_pkg::CMD_MAKE_EMPTY: begin
            if (c.list_head != 0) free_after(c.list_head);
            t = take_node();
            if (t == 0) r.status = cll_pkg::STAT_NO_SPACE;
            else begin
               model_next[t] = 0;
               r.result_position = t;
            end
         end
         cll_pkg::CMD_INSERT: begin
            t = take_node();
            if (t == 0) r.status = cll_pkg::STAT_NO_SPACE;
            else begin
               model_elem[t] = c.value;
               elem_written[t] = 1'b1;
               model_next[t] = model_next[c.position];
               model_next[c.position] = t;
               r.result_position = t;
            end
         end
         cll_pkg::CMD_DELETE: begin
            p = c.list_head;
            steps = 0;
            hit = 1'b0;
            while (steps < NODES) begin
               n = model_next[p];
               if (n == 0) break;
               if (model_elem[n] == c.value) begin
                  hit = 1'b1;
                  break;
               end
               p = n;
               steps++;
            end
            if (hit) begin
               victim = model_next[p];
               model_next[p] = model_next[victim];
               give_node(victim);
               r.result_position = victim;
            end else r.status = cll_pkg::STAT_NOT_FOUND;
         end
         cll_pkg::CMD_FIND: begin
            p = model_next[c.list_head];
            steps = 0;
            while (p != 0 && model_elem[p] != c.value && steps < NODES) begin
               p = model_next[p];
               steps++;
            end
            if (p != 0 && model_elem[p] == c.value) r.result_position = p;
            else r.status = cll_pkg::STAT_NOT_FOUND;
         end
         cll_pkg::CMD_DELETE_LIST: free_after(c.list_head);
         cll_pkg::CMD_READ_NODE: begin
            r.element_out = model_elem[c.position];
            r.next_out = model_next[c.position];
         end
         default: ;
      endcase
      return r;
   endfunction

   // walks from a node must never meet an element that was never written
   function automatic bit walk_is_clean(logic [7:0] hd);
      logic [7:0] p;
      p = model_next[hd];
      for (int s = 0; s < NODES && p != 0; s++) begin
         if (!elem_written[p]) return 1'b0;
         p = model_next[p];
      end
      return 1'b1;
   endfunction

   // planning copy used while the stimulus is built
   logic [7:0]  plan_next [NODES];
   logic [31:0] plan_elem [NODES];
   bit          plan_written [NODES];
   logic [7:0]  live_heads [$];
   logic [31:0] used_values [$];

   function automatic logic [31:0] pick_value();
      if (used_values.size() > 0 && $urandom_range(0, 2) != 0)
         return used_values[$urandom_range(0, used_values.size() - 1)];
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   // push a command if it is legal against the planning state
   task automatic plan_command(input cll_pkg::cmd_type op, input logic [7:0] hd,
                               input logic [7:0] pos, input logic [31:0] v);
      cll_pkg::req_type c;
      cll_pkg::rsp_type r;
      bit ok;
      c.cmd = op;
      c.list_head = hd;
      c.position = pos;
      c.value = v;
      model_next = plan_next;
      model_elem = plan_elem;
      elem_written = plan_written;
      ok = 1'b1;
      if (op == cll_pkg::CMD_DELETE || op == cll_pkg::CMD_FIND) ok = walk_is_clean(hd);
      if (op == cll_pkg::CMD_READ_NODE) ok = elem_written[pos];
      if (!ok) return;
      r = apply_command(c);
      plan_next = model_next;
      plan_elem = model_elem;
      plan_written = elem_written;
      pending_cmds.push_back(c);
      if (op == cll_pkg::CMD_MAKE_EMPTY && r.status == cll_pkg::STAT_OK)
         live_heads.push_back(r.result_position);
      if (op == cll_pkg::CMD_INSERT) used_values.push_back(v);
      if (op == cll_pkg::CMD_INIT || live_heads.size() > 12) live_heads.delete();
   endtask

   function automatic logic [7:0] pick_head();
      if (live_heads.size() == 0) return 8'd0;
      return live_heads[$urandom_range(0, live_heads.size() - 1)];
   endfunction

   initial begin
      logic [7:0] hd;
      int k;
      for (int i = 0; i < NODES; i++) begin
         plan_next[i] = 8'((i + 1) % NODES);
         plan_elem[i] = '0;
         plan_written[i] = 1'b0;
      end
      // directed: header, extremes of value, every command, exhaustion
      plan_command(cll_pkg::CMD_MAKE_EMPTY, 8'd0, 8'd0, 32'd0);
      hd = 8'd1;
      plan_command(cll_pkg::CMD_INSERT, hd, hd, 32'h8000_0000);
      plan_command(cll_pkg::CMD_INSERT, hd, hd, 32'h7fff_ffff);
      plan_command(cll_pkg::CMD_INSERT, hd, 8'd2, 32'hffff_ffff);
      plan_command(cll_pkg::CMD_FIND, hd, 8'd0, 32'hffff_ffff);
      plan_command(cll_pkg::CMD_FIND, hd, 8'd0, 32'h1234_5678);
      plan_command(cll_pkg::CMD_READ_NODE, hd, 8'd2, 32'd0);
      plan_command(cll_pkg::CMD_READ_NODE, hd, 8'd0, 32'd0);
      plan_command(cll_pkg::CMD_DELETE, hd, 8'd0, 32'h7fff_ffff);
      plan_command(cll_pkg::CMD_DELETE, hd, 8'd0, 32'h5555_aaaa);
      plan_command(cll_pkg::CMD_DELETE_LIST, hd, 8'd0, 32'd0);
      plan_command(cll_pkg::CMD_MAKE_EMPTY, hd, 8'd0, 32'd0);
      plan_command(cll_pkg::cmd_type'(3'd7), 8'hff, 8'hff, 32'hffff_ffff);
      // fill the store until allocation fails, then read the last node
      for (int i = 0; i < 256; i++) plan_command(cll_pkg::CMD_INSERT, hd, hd, 32'(i));
      plan_command(cll_pkg::CMD_MAKE_EMPTY, 8'd0, 8'd0, 32'd0);
      plan_command(cll_pkg::CMD_READ_NODE, 8'd0, 8'd255, 32'd0);
      plan_command(cll_pkg::CMD_DELETE_LIST, hd, 8'd0, 32'd0);
      plan_command(cll_pkg::CMD_DELETE_LIST, 8'd0, 8'd0, 32'd0);
      plan_command(cll_pkg::CMD_INIT, 8'd0, 8'd0, 32'd0);
      live_heads.delete();
      // random: mostly well formed list work with some misuse mixed in
      k = 0;
      while (pending_cmds.size() < 600) begin
         k = $urandom_range(0, 99);
         hd = pick_head();
         if (k < 8) plan_command(cll_pkg::CMD_MAKE_EMPTY,
                                 ($urandom_range(0, 1) ? hd : 8'd0), 8'd0, $urandom());
         else if (k < 45) plan_command(cll_pkg::CMD_INSERT, hd,
                                 ($urandom_range(0, 9) == 0) ? 8'($urandom()) : hd,
                                 pick_value());
         else if (k < 60) plan_command(cll_pkg::CMD_DELETE, hd, 8'($urandom()),
                                       pick_value());
         else if (k < 75) plan_command(cll_pkg::CMD_FIND, hd, 8'($urandom()),
                                       pick_value());
         else if (k < 80) plan_command(cll_pkg::CMD_DELETE_LIST, hd, 8'($urandom()),
                                       $urandom());
         else if (k < 95) plan_command(cll_pkg::CMD_READ_NODE, 8'($urandom()),
                                       8'($urandom()), $urandom());
         else if (k < 97) plan_command(cll_pkg::cmd_type'(3'd7), 8'($urandom()),
                                       8'($urandom()), $urandom());
         else if (k < 98) plan_command(cll_pkg::CMD_INIT, 8'd0, 8'd0, 32'd0);
         else plan_command(cll_pkg::CMD_DELETE_LIST, 8'($urandom()), 8'd0, 32'd0);
      end
      for (int i = 0; i < NODES; i++) begin
         model_next[i] = 8'((i + 1) % NODES);
         model_elem[i] = '0;
         elem_written[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
         send_gap <= 0;
      end else begin
         // the accepted command leaves the queue, so the next one is at the front
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(apply_command(req_ch.payload));
            void'(pending_cmds.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
         end else if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cmds.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_cmds[0];
            send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                      : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
         end else begin
            req_ch.valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // monitor and receiver stalls
   int stall_cnt = 0;
   int accepted_rsps = 0;
   always @(posedge clock) begin
      cll_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            accepted_rsps <= accepted_rsps + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_ch.payload);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.payload !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want,
                           rsp_ch.payload);
                  error_count++;
               end
            end
         end
         // one long hold-off lets the block fill and stall its input
         if (accepted_rsps == 40 && !hold_off) begin
            hold_off <= 1'b1;
            stall_cnt <= 300;
            rsp_ch.ready <= 1'b0;
         end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                       : $urandom_range(0, 3);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      wait (stim_done && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
